// ----- hdl/ctt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared constants, table builders and helpers for the color temperature block.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // width of a log2(x/100) value, q16
  localparam int unsigned LG_W = 20;

  // stage counts of the units
  localparam int unsigned LOG_LAT  = 3;
  localparam int unsigned LNCH_LAT = 3;
  localparam int unsigned POW_LAT  = 19;
  localparam int unsigned PIPE_LAT = 1 + LOG_LAT + POW_LAT + 1;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [24:0] RED_SCALE_Q16     = 25'd21607136;
  localparam logic [17:0] RED_EXP_Q20       = 18'd139675;
  localparam logic [23:0] GRN_LOG_SCALE_Q16 = 24'd6518918;
  localparam logic [24:0] GRN_LOG_OFF_Q16   = 25'd10559132;
  localparam logic [24:0] GRN_SCALE_Q16     = 25'd18882374;
  localparam logic [17:0] GRN_EXP_Q20       = 18'd79183;
  localparam logic [23:0] BLU_LOG_SCALE_Q16 = 24'd9077898;
  localparam logic [24:0] BLU_LOG_OFF_Q16   = 25'd19991416;

  localparam logic [15:0] K_MIN      = 16'd1000;
  localparam logic [15:0] K_MAX      = 16'd50000;
  localparam logic [15:0] K_T66      = 16'd6600;
  localparam logic [15:0] K_T19      = 16'd1900;
  localparam logic [15:0] K_POW_OFF  = 16'd6000;
  localparam logic [15:0] K_BLU_OFF  = 16'd1000;

  localparam logic signed [31:0] BYTE_FULL_Q16 = 32'sd16711680;

  // log2(y) fraction bits by repeated q30 squaring, y in [1,2)
  function automatic logic [16:0] log_rounds(input logic [63:0] y0);
    logic [63:0] y;
    logic [16:0] acc;
    y   = y0;
    acc = '0;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y      = y >> 1;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    logic        go;
    v  = v0;
    r  = '0;
    b  = 64'd1 << 62;
    go = 1'b0;
    for (int j = 0; j < 64; j++) begin
      if (!go && (b > v)) begin
        b = b >> 2;
      end else if (b != 64'd0) begin
        go = 1'b1;
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^-(2^-k) in q30
  function automatic logic [30:0] exp_factor(input int unsigned k);
    logic [63:0] e;
    e = isqrt64(64'd1 << 59);
    for (int unsigned j = 2; j <= k; j++) begin
      e = isqrt64(e << 30);
    end
    return e[30:0];
  endfunction

  // clamp a q16 value to 0..255 and round half up
  function automatic logic [7:0] to_byte(input logic signed [31:0] v);
    logic signed [31:0] c;
    logic [31:0]        r;
    if (v < 0) begin
      c = '0;
    end else if (v > BYTE_FULL_Q16) begin
      c = BYTE_FULL_Q16;
    end else begin
      c = v;
    end
    r = $unsigned(c) + 32'd32768;
    return r[23:16];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ctt_log2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_log2
// Three-stage log2(x/100) in q16: normalize, table lookup, interpolate.
// ----------------------------------------------------------------------------
module ctt_log2 #(
  parameter int unsigned LOG_TABLE_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [15:0]              x_i,
  output logic [ctt_pkg::LG_W-1:0] lg_o
);
  import ctt_pkg::*;

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned ROM_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int unsigned S_W   = 30 + IDX_W;

  // log2(100) worked out the same way as the datapath
  localparam logic [63:0] S100   = (64'd36 << 24) * LOG_TABLE_DEPTH;
  localparam logic [63:0] IDX100 = S100 >> 30;
  localparam logic [63:0] REM100 = S100 & ((64'd1 << 30) - 64'd1);
  localparam logic [63:0] LO100  =
    64'(log_rounds(((64'(LOG_TABLE_DEPTH) + IDX100) << 30) / LOG_TABLE_DEPTH));
  localparam logic [63:0] HI100  = (IDX100 + 64'd1 == 64'(LOG_TABLE_DEPTH)) ? 64'd65536 :
    64'(log_rounds(((64'(LOG_TABLE_DEPTH) + IDX100 + 64'd1) << 30) / LOG_TABLE_DEPTH));
  localparam logic [63:0] PART100 = (HI100 > LO100) ? (((HI100 - LO100) * REM100) >> 30)
                                                    : 64'd0;
  localparam logic [20:0] LOG2_100 = 21'((64'd6 << 16) + LO100 + PART100);

  logic [16:0] rom [LOG_TABLE_DEPTH+1];

  for (genvar i = 0; i <= LOG_TABLE_DEPTH; i++) begin : g_rom
    if (i == LOG_TABLE_DEPTH) begin : g_top
      assign rom[i] = 17'd65536;
    end else begin : g_ent
      localparam logic [63:0] Y0 = (64'(LOG_TABLE_DEPTH + i) << 30) / LOG_TABLE_DEPTH;
      assign rom[i] = log_rounds(Y0);
    end
  end

  // stage 1: msb and mantissa
  logic [3:0]  e_d, e_q;
  logic [45:0] y;
  logic [29:0] frac_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < 16; i++) begin
      if (x_i[i]) e_d = 4'(i);
    end
  end

  assign y = 46'(x_i) << (5'd30 - 5'(e_d));

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    frac_q <= y[29:0];
  end

  // stage 2: table index and pair lookup
  logic [S_W-1:0]   s;
  logic [IDX_W-1:0] idx;
  logic [16:0]      lo, hi;
  logic [3:0]       e2_q;
  logic [16:0]      lo_q, diff_q;
  logic [29:0]      rem_q;

  assign s   = S_W'(frac_q) * S_W'(LOG_TABLE_DEPTH);
  assign idx = s[S_W-1:30];
  assign lo  = rom[ROM_W'(idx)];
  assign hi  = rom[ROM_W'(idx) + ROM_W'(1)];

  always_ff @(posedge clk_i) begin
    e2_q   <= e_q;
    lo_q   <= lo;
    diff_q <= (hi > lo) ? (hi - lo) : 17'd0;
    rem_q  <= s[29:0];
  end

  // stage 3: interpolate and subtract log2(100)
  logic [46:0]      part;
  logic [20:0]      a;
  logic [LG_W-1:0]  lg_q;

  assign part = (47'(diff_q) * 47'(rem_q)) >> 30;
  assign a    = {1'b0, e2_q, 16'd0} + 21'(lo_q) + 21'(part[16:0]);

  always_ff @(posedge clk_i) begin
    lg_q <= (a > LOG2_100) ? LG_W'(a - LOG2_100) : '0;
  end

  assign lg_o = lg_q;

endmodule
`default_nettype wire

// ----- hdl/ctt_lnch.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_lnch
// Logarithmic channel: scale * ln(x/100) - offset, clamped to a byte.
// ----------------------------------------------------------------------------
module ctt_lnch #(
  parameter logic [23:0] SCALE = 24'd0,
  parameter logic [24:0] OFF   = 25'd0
) (
  input  logic                     clk_i,
  input  logic [ctt_pkg::LG_W-1:0] lg_i,
  output logic [7:0]               byte_o
);
  import ctt_pkg::*;

  logic [49:0]        ln_p;
  logic [LG_W-1:0]    ln_q;
  logic [43:0]        sc_p;
  logic signed [31:0] v_d, v_q;
  logic [7:0]         byte_q;

  assign ln_p = (50'(lg_i) * 50'(LN2_Q30)) >> 30;

  always_ff @(posedge clk_i) begin
    ln_q <= ln_p[LG_W-1:0];
  end

  assign sc_p = 44'(ln_q) * 44'(SCALE);
  assign v_d  = $signed({4'd0, sc_p[43:16]}) - $signed({7'd0, OFF});

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    byte_q <= to_byte(v_q);
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

// ----- hdl/ctt_pow.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pow
// Power-law channel: scale * 2^-(mag * log2(d/100)), one factor per stage.
// ----------------------------------------------------------------------------
module ctt_pow #(
  parameter logic [24:0] SCALE = 25'd0,
  parameter logic [17:0] MAG   = 18'd0
) (
  input  logic                     clk_i,
  input  logic [ctt_pkg::LG_W-1:0] lg_i,
  output logic [7:0]               byte_o
);
  import ctt_pkg::*;

  logic [37:0] m;
  logic [30:0] acc_q [17];
  logic [15:0] f_q   [17];
  logic [1:0]  n_q   [17];

  assign m = (38'(lg_i) * 38'(MAG)) >> 20;

  always_ff @(posedge clk_i) begin
    acc_q[0] <= 31'h4000_0000;
    f_q[0]   <= m[15:0];
    n_q[0]   <= m[17:16];
  end

  // one exponent bit per stage, msb first
  for (genvar k = 1; k <= 16; k++) begin : g_stage
    localparam logic [30:0] FK = exp_factor(k);
    logic [61:0] prod;
    assign prod = 62'(acc_q[k-1]) * 62'(FK);
    always_ff @(posedge clk_i) begin
      acc_q[k] <= f_q[k-1][16-k] ? prod[60:30] : acc_q[k-1];
      f_q[k]   <= f_q[k-1];
      n_q[k]   <= n_q[k-1];
    end
  end

  logic [30:0] sh;
  logic [55:0] sc_p;
  logic [25:0] v_q;
  logic [7:0]  byte_q;

  assign sh   = acc_q[16] >> n_q[16];
  assign sc_p = 56'(sh) * 56'(SCALE);

  always_ff @(posedge clk_i) begin
    v_q    <= sc_p[55:30];
    byte_q <= to_byte($signed({6'd0, v_q}));
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

// ----- hdl/color_temperature_to_rgb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// color_temperature_to_rgb
// Blackbody color temperature in kelvin to an 8-bit RGB triple.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kelvin_i and raise start for one beat; busy is always low, so a
//   beat is taken on every cycle that start is high. Each beat returns one
//   red/green/blue triple on red_o, green_o, blue_o with valid_o high
//   for exactly one cycle.
//   Throughput is one beat per cycle; the latency is set by the power-law
//   unit, which applies one exponent factor per stage over 16 stages, plus
//   the three-stage log2 unit, the input and the output register.
//   The receiver cannot stall, and results leave in beat order.
//   Reset clears the valid chain only; beats in flight are dropped and the
//   block takes a new beat in the first cycle after reset is released.
//   kelvin_i is saturated to 1000..50000 before use.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb #(
  parameter int unsigned LOG_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] kelvin_i,
  output logic        valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import ctt_pkg::*;

  localparam int unsigned FLAG_DLY = LOG_LAT + POW_LAT;
  localparam int unsigned LN_DLY   = POW_LAT - LNCH_LAT;

  typedef struct packed {
    logic low;     // t at most 66
    logic b_full;  // t at least 66
    logic b_zero;  // t at most 19
  } flags_t;

  assign busy = 1'b0;

  // valid chain
  logic [PIPE_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], start};
    end
  end

  // input stage: saturate and pick log arguments
  logic [15:0] k_sat;
  flags_t      fl_d;
  logic [15:0] xa_q, xb_q;
  flags_t      fl_q [FLAG_DLY+1];

  always_comb begin
    if (kelvin_i < K_MIN) begin
      k_sat = K_MIN;
    end else if (kelvin_i > K_MAX) begin
      k_sat = K_MAX;
    end else begin
      k_sat = kelvin_i;
    end
    fl_d.low    = (k_sat <= K_T66);
    fl_d.b_full = (k_sat >= K_T66);
    fl_d.b_zero = (k_sat <= K_T19);
  end

  always_ff @(posedge clk_i) begin
    xa_q     <= fl_d.low ? k_sat : (k_sat - K_POW_OFF);
    xb_q     <= k_sat - K_BLU_OFF;
    fl_q[0]  <= fl_d;
    for (int i = 1; i <= FLAG_DLY; i++) begin
      fl_q[i] <= fl_q[i-1];
    end
  end

  logic [LG_W-1:0] lga, lgb;

  ctt_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_a (
    .clk_i(clk_i), .x_i(xa_q), .lg_o(lga)
  );

  ctt_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_b (
    .clk_i(clk_i), .x_i(xb_q), .lg_o(lgb)
  );

  logic [7:0] g_ln, b_ln, r_pw, g_pw;

  ctt_lnch #(.SCALE(GRN_LOG_SCALE_Q16), .OFF(GRN_LOG_OFF_Q16)) u_grn_ln (
    .clk_i(clk_i), .lg_i(lga), .byte_o(g_ln)
  );

  ctt_lnch #(.SCALE(BLU_LOG_SCALE_Q16), .OFF(BLU_LOG_OFF_Q16)) u_blu_ln (
    .clk_i(clk_i), .lg_i(lgb), .byte_o(b_ln)
  );

  ctt_pow #(.SCALE(RED_SCALE_Q16), .MAG(RED_EXP_Q20)) u_red_pw (
    .clk_i(clk_i), .lg_i(lga), .byte_o(r_pw)
  );

  ctt_pow #(.SCALE(GRN_SCALE_Q16), .MAG(GRN_EXP_Q20)) u_grn_pw (
    .clk_i(clk_i), .lg_i(lga), .byte_o(g_pw)
  );

  // line up the log channels with the power-law ones
  logic [7:0] g_ln_q [LN_DLY];
  logic [7:0] b_ln_q [LN_DLY];

  always_ff @(posedge clk_i) begin
    g_ln_q[0] <= g_ln;
    b_ln_q[0] <= b_ln;
    for (int i = 1; i < LN_DLY; i++) begin
      g_ln_q[i] <= g_ln_q[i-1];
      b_ln_q[i] <= b_ln_q[i-1];
    end
  end

  flags_t     fl_o;
  logic [7:0] red_q, green_q, blue_q;

  assign fl_o = fl_q[FLAG_DLY];

  always_ff @(posedge clk_i) begin
    red_q   <= fl_o.low ? 8'd255 : r_pw;
    green_q <= fl_o.low ? g_ln_q[LN_DLY-1] : g_pw;
    if (fl_o.b_full) begin
      blue_q <= 8'd255;
    end else if (fl_o.b_zero) begin
      blue_q <= 8'd0;
    end else begin
      blue_q <= b_ln_q[LN_DLY-1];
    end
  end

  assign valid_o = vld_q[PIPE_LAT-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef SYNTH
  a_hot_blue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kelvin_i >= K_T66) |-> ##PIPE_LAT (valid_o && blue_o == 8'd255))
    else $error("blue not full scale for a hot beat");

  a_cold_blue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kelvin_i <= K_T19) |-> ##PIPE_LAT (valid_o && blue_o == 8'd0))
    else $error("blue not zero for a cold beat");

  a_warm_red_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kelvin_i <= K_T66) |-> ##PIPE_LAT (valid_o && red_o == 8'd255))
    else $error("red not full scale for a warm beat");

  a_no_beat_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##PIPE_LAT !valid_o)
    else $error("result without a beat");
`endif

endmodule
`default_nettype wire

// ----- tb/color_temperature_to_rgb_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_tb
// Streams kelvin beats through the block under random start gaps and checks
// every rgb triple against a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb_tb;
  import ctt_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [15:0] k_list[22] = '{
    16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1899, 16'd1900, 16'd1901, 16'd2000,
    16'd4000, 16'd6599, 16'd6600, 16'd6601, 16'd6699, 16'd6700, 16'd10000,
    16'd49999, 16'd50000, 16'd50001, 16'd65535, 16'h5555, 16'hAAAA, 16'h7FFF
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] kelvin_i;
  logic        valid_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;

  logic [15:0] kelvin_queue[$];
  rgb_t        rgb_expected[$];
  longint unsigned log2_frac_rom[DEPTH+1];
  longint unsigned halving_rom[17];
  int          mismatches;
  int          cycles;
  int          gap_pct;
  bit          feeding_done;

  color_temperature_to_rgb #(.LOG_TABLE_DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kelvin_i(kelvin_i), .valid_o(valid_o), .red_o(red_o),
    .green_o(green_o), .blue_o(blue_o)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned v0);
    longint unsigned v, r, b;
    v = v0;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void fill_roms();
    longint unsigned y;
    longint unsigned acc;
    for (int i = 0; i < DEPTH; i++) begin
      y = ((64'(DEPTH + i)) << 30) / DEPTH;
      acc = 0;
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          acc = acc | (64'd1 << b);
        end
      end
      log2_frac_rom[i] = acc;
    end
    log2_frac_rom[DEPTH] = 65536;
    halving_rom[0] = 64'd1 << 30;
    halving_rom[1] = int_sqrt(64'd1 << 59);
    for (int k = 2; k <= 16; k++) halving_rom[k] = int_sqrt(halving_rom[k-1] << 30);
  endfunction

  function automatic longint unsigned log2_fixed(input longint unsigned x);
    longint unsigned e, y, frac, s, idx, rem, lo, hi, part;
    e = 0;
    if (x == 0) return 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    y = x << (30 - e);
    frac = (y - (64'd1 << 30)) & ((64'd1 << 30) - 1);
    s = frac * DEPTH;
    idx = s >> 30;
    if (idx >= DEPTH) idx = DEPTH - 1;
    rem = s & ((64'd1 << 30) - 1);
    lo = log2_frac_rom[idx];
    hi = log2_frac_rom[idx+1];
    part = (hi > lo) ? (((hi - lo) * rem) >> 30) : 0;
    return (e << 16) + lo + part;
  endfunction

  function automatic longint unsigned log2_per_100(input longint unsigned x);
    longint unsigned a, b;
    a = log2_fixed(x);
    b = log2_fixed(100);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic longint log_curve(input longint unsigned scale, input longint off,
                                       input longint unsigned x);
    longint unsigned ln;
    ln = (log2_per_100(x) * 64'd744261118) >> 30;
    return longint'((scale * ln) >> 16) - off;
  endfunction

  function automatic longint power_curve(input longint unsigned scale,
                                         input longint unsigned mag,
                                         input longint unsigned d);
    longint unsigned m, n, f, acc;
    m = (mag * log2_per_100(d)) >> 20;
    n = m >> 16;
    f = m & 64'hFFFF;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if ((f >> (16 - k)) & 1) acc = (acc * halving_rom[k]) >> 30;
    acc = (n < 31) ? (acc >> n) : 0;
    return longint'((scale * acc) >> 30);
  endfunction

  function automatic logic [7:0] q16_to_byte(input longint v0);
    longint v;
    longint unsigned r;
    v = v0;
    if (v < 0) v = 0;
    if (v > (64'sd255 << 16)) v = 64'sd255 << 16;
    r = (longint'(v) + 32768) >> 16;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic rgb_t kelvin_to_rgb(input logic [15:0] raw);
    longint unsigned k;
    rgb_t c;
    k = raw;
    if (k < 1000) k = 1000;
    if (k > 50000) k = 50000;
    if (k <= 6600) begin
      c.red = 8'd255;
      c.green = q16_to_byte(log_curve(6518918, 10559132, k));
    end else begin
      c.red = q16_to_byte(power_curve(21607136, 139675, k - 6000));
      c.green = q16_to_byte(power_curve(18882374, 79183, k - 6000));
    end
    if (k >= 6600) c.blue = 8'd255;
    else if (k <= 1900) c.blue = 8'd0;
    else c.blue = q16_to_byte(log_curve(9077898, 19991416, k - 1000));
    return c;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver: one beat per accepted start
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) rgb_expected = {rgb_expected, kelvin_to_rgb(kelvin_i)};
      if ((!start || !busy) && kelvin_queue.size() != 0 &&
          $urandom_range(99) >= gap_pct) begin
        start    <= 1'b1;
        kelvin_i <= kelvin_queue.pop_front();
      end else if (!start || !busy) begin
        start    <= 1'b0;
        kelvin_i <= 16'($urandom);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && valid_o) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %0d/%0d/%0d", red_o, green_o, blue_o);
      end else begin
        want = rgb_expected.pop_front();
        if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgb mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (kelvin_queue.size() != 0 || start || rgb_expected.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] k;
    mismatches = 0;
    cycles = 0;
    gap_pct = 0;
    start = 1'b0;
    kelvin_i = '0;
    rst_ni = 1'b0;
    fill_roms();
    // saturation, both boundaries and their neighbors, extremes of the input
    foreach (k_list[i]) kelvin_queue = {kelvin_queue, k_list[i]};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: gap_pct = 0;
        1: gap_pct = 61;
        2: gap_pct = 32;
        default: gap_pct = 0;
      endcase
      for (int i = 0; i < 260; i++) begin
        case ($urandom_range(9))
          0: k = 16'($urandom);
          1: k = 16'($urandom_range(6550, 6650));
          2: k = 16'($urandom_range(1850, 1950));
          3: k = 16'($urandom_range(50000, 65535));
          4: k = 16'($urandom_range(0, 1100));
          default: k = 16'($urandom_range(1000, 50000));
        endcase
        kelvin_queue = {kelvin_queue, k};
      end
      drain();
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
